@@ rtl/core/assert_macros.svh @@
// Assertion macros for the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, inactive while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, inactive while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

@@ rtl/core/i2cm_pkg.sv @@
// Types, constants and register codes of the I2C master byte engine.
package i2cm_pkg;

	localparam int QUEUE_DEPTH = 4;

	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_UNIT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_ACK_TIMEOUT    = 1'b1;

	localparam logic [7:0] TICKS_PER_UNIT_RESET = 8'd8;
	localparam logic [7:0] ACK_TIMEOUT_RESET    = 8'd250;

	localparam logic [2:0] FUNC_NONE  = 3'd0;
	localparam logic [2:0] FUNC_START = 3'd1;
	localparam logic [2:0] FUNC_STOP  = 3'd2;
	localparam logic [2:0] FUNC_WRITE = 3'd3;
	localparam logic [2:0] FUNC_READ  = 3'd4;

	localparam logic [3:0] BITS_PER_BYTE = 4'd8;

	typedef enum logic [2:0] {
		CMD_NONE,
		CMD_START,
		CMD_STOP,
		CMD_WRITE,
		CMD_READ
	} cmd_t;

	typedef enum logic [3:0] {
		PH_IDLE,
		PH_START_A,
		PH_START_B,
		PH_STOP_A,
		PH_STOP_B,
		PH_WR_LOW,
		PH_WR_HIGH,
		PH_ACK_LOW,
		PH_ACK_RISE,
		PH_ACK_WAIT,
		PH_RD_LOW,
		PH_RD_HIGH,
		PH_ANS_LOW,
		PH_ANS_HIGH
	} phase_t;

	typedef struct packed {
		logic [2:0] func;
		logic [7:0] tx_byte;
		logic       send_nack;
		logic       sda_in;
	} in_item_t;

	typedef struct packed {
		logic       scl_out;
		logic       sda_out;
		logic       sda_drive;
		logic       busy_res;
		logic       done_res;
		logic [7:0] rx_byte;
		logic       ack_missing;
	} out_item_t;

	typedef struct packed {
		cmd_t       cmd;
		logic [7:0] tx_byte;
		logic       send_nack;
		logic       sda_in;
	} tick_t;

	typedef struct packed {
		logic scl;
		logic sda;
		logic drv;
	} lines_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_stat_t;

endpackage

@@ rtl/core/i2cm_front.sv @@
// Front end: accepts tick items and classifies the command code.
module i2cm_front import i2cm_pkg::*; (
	input  logic        in_valid,
	output logic        in_stall,
	input  in_item_t    in_item,
	input  queue_stat_t stat,
	output logic        push,
	output tick_t       push_item
);

	cmd_t cmd;

	always_comb begin
		unique case (in_item.func)
			FUNC_START: cmd = CMD_START;
			FUNC_STOP:  cmd = CMD_STOP;
			FUNC_WRITE: cmd = CMD_WRITE;
			FUNC_READ:  cmd = CMD_READ;
			default:    cmd = CMD_NONE;
		endcase
	end

	assign in_stall = stat.full;
	assign push     = in_valid && !stat.full;

	assign push_item.cmd       = cmd;
	assign push_item.tx_byte   = in_item.tx_byte;
	assign push_item.send_nack = in_item.send_nack;
	assign push_item.sda_in    = in_item.sda_in;

endmodule

@@ rtl/core/i2cm_queue.sv @@
// Short first-in first-out queue of classified ticks between front and engine.
module i2cm_queue import i2cm_pkg::*; #(
	parameter int Depth = QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  tick_t       push_item,
	input  logic        pop,
	output tick_t       pop_item,
	output queue_stat_t stat
);

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
	localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

	tick_t           entries_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign pop_item   = entries_q[rd_ptr_q];
	assign stat.full  = (count_q == FullCnt);
	assign stat.empty = (count_q == '0);

endmodule

@@ rtl/core/i2cm_engine.sv @@
// Back end: bus phase machine, one tick per unstalled cycle; result register.
module i2cm_engine import i2cm_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]           cfg_data,
	input  tick_t                pop_item,
	input  queue_stat_t          stat,
	output logic                 pop,
	output logic                 out_valid,
	input  logic                 out_stall,
	output out_item_t            out_item
);

	logic [7:0] tpu_q;
	logic [7:0] ack_timeout_q;

	phase_t     phase_q, n_phase;
	logic [9:0] delay_q, n_delay;
	logic [3:0] bit_q, n_bit;
	logic [7:0] shift_q, n_shift;
	logic [7:0] wait_q, n_wait;
	lines_t     lines_q, n_lines;
	logic       nack_q, n_nack;
	logic       miss_q, n_miss;
	logic       n_done;
	logic [7:0] rx_q, n_rx;

	logic       out_valid_q;
	out_item_t  out_item_q;
	logic       advance;

	logic [7:0] unit;
	logic [9:0] dly1, dly2, dly4;
	logic [7:0] sh_next;
	logic [3:0] bit_next;

	assign advance = !stat.empty && (!out_valid_q || !out_stall);
	assign pop     = advance;

	// A zero unit length counts as one tick.
	assign unit = (tpu_q == 8'd0) ? 8'd1 : tpu_q;
	assign dly1 = {2'b00, unit} - 10'd1;
	assign dly2 = {1'b0, unit, 1'b0} - 10'd1;
	assign dly4 = {unit, 2'b00} - 10'd1;

	always_comb begin
		n_phase  = phase_q;
		n_delay  = delay_q;
		n_bit    = bit_q;
		n_shift  = shift_q;
		n_wait   = wait_q;
		n_lines  = lines_q;
		n_nack   = nack_q;
		n_miss   = miss_q;
		n_rx     = rx_q;
		n_done   = 1'b0;
		sh_next  = 8'd0;
		bit_next = bit_q + 4'd1;

		if (phase_q == PH_IDLE) begin
			unique case (pop_item.cmd)
				CMD_START: begin
					n_phase = PH_START_A;
					n_delay = dly4;
					n_lines = '{scl: 1'b1, sda: 1'b1, drv: 1'b1};
				end
				CMD_STOP: begin
					n_phase = PH_STOP_A;
					n_delay = dly4;
					n_lines = '{scl: 1'b0, sda: 1'b0, drv: 1'b1};
				end
				CMD_WRITE: begin
					n_shift = pop_item.tx_byte;
					n_bit   = 4'd0;
					n_miss  = 1'b0;
					n_phase = PH_WR_LOW;
					n_delay = dly2;
					n_lines = '{scl: 1'b0, sda: pop_item.tx_byte[7], drv: 1'b1};
				end
				CMD_READ: begin
					n_shift = 8'd0;
					n_bit   = 4'd0;
					n_nack  = pop_item.send_nack;
					n_phase = PH_RD_LOW;
					n_delay = dly2;
					n_lines = '{scl: 1'b0, sda: 1'b1, drv: 1'b0};
				end
				default: begin
				end
			endcase
		end else if (phase_q == PH_ACK_WAIT) begin
			if (!pop_item.sda_in) begin
				n_lines.scl = 1'b0;
				n_phase     = PH_IDLE;
				n_delay     = 10'd0;
				n_done      = 1'b1;
			end else if (wait_q >= ack_timeout_q) begin
				// No acknowledge in time: release the bus with a stop of our own.
				n_miss  = 1'b1;
				n_phase = PH_STOP_A;
				n_delay = dly4;
				n_lines = '{scl: 1'b0, sda: 1'b0, drv: 1'b1};
			end else begin
				n_wait = wait_q + 8'd1;
			end
		end else if (delay_q != 10'd0) begin
			n_delay = delay_q - 10'd1;
		end else begin
			unique case (phase_q)
				PH_START_A: begin
					n_phase = PH_START_B;
					n_delay = dly4;
					n_lines = '{scl: 1'b1, sda: 1'b0, drv: 1'b1};
				end
				PH_START_B: begin
					n_lines = '{scl: 1'b0, sda: 1'b0, drv: 1'b1};
					n_phase = PH_IDLE;
					n_delay = 10'd0;
					n_done  = 1'b1;
				end
				PH_STOP_A: begin
					n_phase = PH_STOP_B;
					n_delay = dly4;
					n_lines = '{scl: 1'b1, sda: 1'b1, drv: 1'b1};
				end
				PH_STOP_B: begin
					n_phase = PH_IDLE;
					n_delay = 10'd0;
					n_done  = 1'b1;
				end
				PH_WR_LOW: begin
					n_phase     = PH_WR_HIGH;
					n_delay     = dly2;
					n_lines.scl = 1'b1;
				end
				PH_WR_HIGH: begin
					sh_next = {shift_q[6:0], 1'b0};
					n_shift = sh_next;
					n_bit   = bit_next;
					if (bit_next < BITS_PER_BYTE) begin
						n_phase = PH_WR_LOW;
						n_delay = dly2;
						n_lines = '{scl: 1'b0, sda: sh_next[7], drv: 1'b1};
					end else begin
						n_wait  = 8'd0;
						n_phase = PH_ACK_LOW;
						n_delay = dly1;
						n_lines = '{scl: 1'b0, sda: 1'b1, drv: 1'b0};
					end
				end
				PH_ACK_LOW: begin
					n_phase = PH_ACK_RISE;
					n_delay = dly1;
					n_lines = '{scl: 1'b1, sda: 1'b1, drv: 1'b0};
				end
				PH_ACK_RISE: begin
					n_phase = PH_ACK_WAIT;
					n_delay = 10'd0;
				end
				PH_RD_LOW: begin
					n_phase = PH_RD_HIGH;
					n_delay = dly2;
					n_lines = '{scl: 1'b1, sda: 1'b1, drv: 1'b0};
				end
				PH_RD_HIGH: begin
					sh_next = {shift_q[6:0], pop_item.sda_in};
					n_shift = sh_next;
					n_bit   = bit_next;
					if (bit_next < BITS_PER_BYTE) begin
						n_phase = PH_RD_LOW;
						n_delay = dly2;
						n_lines = '{scl: 1'b0, sda: 1'b1, drv: 1'b0};
					end else begin
						n_rx    = sh_next;
						n_phase = PH_ANS_LOW;
						n_delay = dly2;
						n_lines = '{scl: 1'b0, sda: nack_q, drv: 1'b1};
					end
				end
				PH_ANS_LOW: begin
					n_phase     = PH_ANS_HIGH;
					n_delay     = dly2;
					n_lines.scl = 1'b1;
				end
				PH_ANS_HIGH: begin
					n_lines.scl = 1'b0;
					n_phase     = PH_IDLE;
					n_delay     = 10'd0;
					n_done      = 1'b1;
				end
				default: begin
					n_phase = PH_IDLE;
					n_delay = 10'd0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tpu_q         <= TICKS_PER_UNIT_RESET;
			ack_timeout_q <= ACK_TIMEOUT_RESET;
			phase_q       <= PH_IDLE;
			delay_q       <= '0;
			bit_q         <= '0;
			shift_q       <= '0;
			wait_q        <= '0;
			lines_q       <= '{scl: 1'b1, sda: 1'b1, drv: 1'b1};
			nack_q        <= 1'b0;
			miss_q        <= 1'b0;
			rx_q          <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_TICKS_PER_UNIT: tpu_q         <= cfg_data;
					REG_ACK_TIMEOUT:    ack_timeout_q <= cfg_data;
					default: begin
					end
				endcase
			end
			if (advance) begin
				phase_q <= n_phase;
				delay_q <= n_delay;
				bit_q   <= n_bit;
				shift_q <= n_shift;
				wait_q  <= n_wait;
				lines_q <= n_lines;
				nack_q  <= n_nack;
				miss_q  <= n_miss;
				rx_q    <= n_rx;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_item_q.scl_out     <= n_lines.scl;
			out_item_q.sda_out     <= n_lines.sda;
			out_item_q.sda_drive   <= n_lines.drv;
			out_item_q.busy_res    <= (n_phase != PH_IDLE);
			out_item_q.done_res    <= n_done;
			out_item_q.rx_byte     <= n_rx;
			out_item_q.ack_missing <= n_miss;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule

@@ rtl/core/i2c_master_byte_engine.sv @@
// Top level of the tick-driven I2C master byte engine.
// Usage: every input item on in_valid/in_stall/in_item is one bus timing tick
// carrying the sampled SDA level and, when the engine is idle, a command
// (start, stop, write byte with ACK check, read byte with ACK or NACK answer).
// Each tick produces exactly one result item on out_valid/out_stall/out_item
// with the pin levels, busy, done pulse, received byte and ACK-missing flag.
// A taken item enters the queue; its result then goes to the result register.
// Throughput: one item per cycle unless stalled; the phase machine retires
// one tick a cycle and the classifying front feeds it through a short queue.
// When the receiver stalls, the result register holds and the queue fills;
// in_stall rises once the queue is full and drops as soon as an entry frees.
// Reset empties the queue and the result register, puts the engine idle with
// SCL and SDA driven high, and loads ticks_per_unit 8 and ack_timeout 250.
// Write registers via cfg_we/cfg_index/cfg_data only while idle (unchecked).
module i2c_master_byte_engine import i2cm_pkg::*; #(
	parameter int QueueDepth = QUEUE_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]           cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  in_item_t             in_item,
	output logic                 out_valid,
	input  logic                 out_stall,
	output out_item_t            out_item
);

	queue_stat_t stat;
	logic        push;
	logic        pop;
	tick_t       push_item;
	tick_t       pop_item;

	i2cm_front u_front (
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.stat      (stat),
		.push      (push),
		.push_item (push_item)
	);

	i2cm_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.pop_item  (pop_item),
		.stat      (stat)
	);

	i2cm_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pop_item  (pop_item),
		.stat      (stat),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

endmodule

@@ rtl/core/i2cm_checker.sv @@
// Port-level checks of the I2C master byte engine and their bind.
`include "assert_macros.svh"

module i2cm_checker import i2cm_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      out_valid,
	input logic      out_stall,
	input out_item_t out_item
);

	// A completed command always leaves the engine idle.
	`ASSERT_IMPL(a_done_not_busy, clk, arst_n, out_valid && out_item.done_res, !out_item.busy_res)

	// A released data line always reads as high.
	`ASSERT_IMPL(a_release_high, clk, arst_n, out_valid && !out_item.sda_drive, out_item.sda_out)

	// Only a stop ends with the clock high, and it leaves the data line driven high.
	`ASSERT_IMPL(a_stop_end, clk, arst_n, out_valid && out_item.done_res && out_item.scl_out,
		out_item.sda_out && out_item.sda_drive)

	// A stalled result stays in place.
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(out_item))

endmodule

bind i2c_master_byte_engine i2cm_checker u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_item  (out_item)
);
